// ===== rtl/core/mbe_pkg.sv =====
// mbe_pkg: shared types, constants and helpers for the escape-time block
// no dependencies; used by mbe_coord, mbe_iter_ring and mandelbrot_escape_time
package mbe_pkg;

   // field widths
   localparam int INDEX_W   = 14;
   localparam int COORD_W   = 32;
   localparam int COUNT_W   = 16;
   localparam int CSR_IDX_W = 3;

   // fixed-point format and image limits
   localparam int FRAC_BITS     = 24;
   localparam int MAX_DIMENSION = 16384;

   // wide working width for sums ahead of saturation
   localparam int WIDE_W = 48;
   localparam int PROD_W = 2 * COORD_W;
   localparam int MAG_W  = 40;

   // escape bound |z|^2 < 4 in the fixed-point scale
   localparam logic [MAG_W-1:0] MAG_LIMIT = MAG_W'(4) << FRAC_BITS;

   // iteration ring
   localparam int RING_DEPTH = 4;
   localparam int SEQ_W      = $clog2(RING_DEPTH);

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_ITER    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_REAL_ORIGIN = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_REAL_STEP   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAG_ORIGIN = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAG_STEP   = 3'd4;

   // register reset values
   localparam logic [COUNT_W-1:0] RST_MAX_ITER = 16'd1000;
   localparam logic [COORD_W-1:0] RST_ORIGIN   = 32'hFE00_0000;
   localparam logic [COORD_W-1:0] RST_STEP     = 32'h0000_4000;

   // point c handed from the coordinate mapper to the ring
   typedef struct packed {
      logic signed [COORD_W-1:0] cre;
      logic signed [COORD_W-1:0] cim;
   } point_type;

   // clamp a wide signed value to the coordinate range
   function automatic logic signed [COORD_W-1:0] sat_coord(input logic signed [WIDE_W-1:0] v);
      logic signed [WIDE_W-1:0] hi;
      logic signed [WIDE_W-1:0] lo;
      hi = WIDE_W'({1'b0, {(COORD_W-1){1'b1}}});
      lo = -hi - WIDE_W'(1);
      if (v > hi) begin
         sat_coord = {1'b0, {(COORD_W-1){1'b1}}};
      end else if (v < lo) begin
         sat_coord = {1'b1, {(COORD_W-1){1'b0}}};
      end else begin
         sat_coord = v[COORD_W-1:0];
      end
   endfunction

endpackage

// ===== rtl/core/mbe_coord.sv =====
// mbe_coord: maps a pixel index pair to the point c in three register stages
// depends on mbe_pkg (point_type, sat_coord, widths)
module mbe_coord (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                accept,
   input  logic [mbe_pkg::INDEX_W-1:0]         column,
   input  logic [mbe_pkg::INDEX_W-1:0]         row,
   input  logic signed [mbe_pkg::COORD_W-1:0]  real_origin,
   input  logic signed [mbe_pkg::COORD_W-1:0]  real_step,
   input  logic signed [mbe_pkg::COORD_W-1:0]  imag_origin,
   input  logic signed [mbe_pkg::COORD_W-1:0]  imag_step,
   output logic                                full,
   output logic                                pt_valid,
   output mbe_pkg::point_type                  pt_beat,
   input  logic                                pt_take
);

   localparam int MUL_W = mbe_pkg::COORD_W + mbe_pkg::INDEX_W + 1;

   logic                              a_valid_ff, b_valid_ff, c_valid_ff;
   logic                              a_valid_in, b_valid_in, c_valid_in;
   logic [mbe_pkg::INDEX_W-1:0]       col_ff, row_ff, col_in, row_in;
   logic signed [MUL_W-1:0]           pre_ff, pim_ff, pre_in, pim_in;
   mbe_pkg::point_type                pt_ff, pt_in;
   logic                              a_open, b_open, c_open;

   // a stage moves when the one after it has room
   assign c_open = !c_valid_ff || pt_take;
   assign b_open = !b_valid_ff || c_open;
   assign a_open = !a_valid_ff || b_open;
   assign full   = a_valid_ff && b_valid_ff && c_valid_ff;

   // stage a: clip the indexes to the image
   always_comb begin
      col_in = (32'(column) >= mbe_pkg::MAX_DIMENSION) ?
               mbe_pkg::INDEX_W'(mbe_pkg::MAX_DIMENSION - 1) : column;
      row_in = (32'(row) >= mbe_pkg::MAX_DIMENSION) ?
               mbe_pkg::INDEX_W'(mbe_pkg::MAX_DIMENSION - 1) : row;
   end

   // stage b: index times step
   assign pre_in = $signed({1'b0, col_ff}) * real_step;
   assign pim_in = $signed({1'b0, row_ff}) * imag_step;

   // stage c: add the origin and saturate
   assign pt_in.cre = mbe_pkg::sat_coord(mbe_pkg::WIDE_W'(pre_ff) +
                                         mbe_pkg::WIDE_W'(real_origin));
   assign pt_in.cim = mbe_pkg::sat_coord(mbe_pkg::WIDE_W'(pim_ff) +
                                         mbe_pkg::WIDE_W'(imag_origin));

   // valid bits
   always_comb begin
      a_valid_in = a_open ? accept : a_valid_ff;
      b_valid_in = b_open ? a_valid_ff : b_valid_ff;
      c_valid_in = c_open ? b_valid_ff : c_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
         b_valid_ff <= b_valid_in;
         c_valid_ff <= c_valid_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (a_open) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
      if (b_open) begin
         pre_ff <= pre_in;
         pim_ff <= pim_in;
      end
      if (c_open) begin
         pt_ff <= pt_in;
      end
   end

   assign pt_valid = c_valid_ff;
   assign pt_beat  = pt_ff;

endmodule

// ===== rtl/core/mbe_iter_ring.sv =====
// mbe_iter_ring: four-stage recirculating z = z*z + c unit with in-order retire
// depends on mbe_pkg (point_type, sat_coord, widths, ring constants)
module mbe_iter_ring (
   input  logic                               clock,
   input  logic                               reset,
   input  logic [mbe_pkg::COUNT_W-1:0]        max_iterations,
   input  logic                               pt_valid,
   input  mbe_pkg::point_type                 pt_beat,
   output logic                               pt_take,
   output logic                               rsp_strobe,
   output logic [mbe_pkg::COUNT_W-1:0]        rsp_iteration_count
);

   typedef struct packed {
      logic                               done;
      logic [mbe_pkg::SEQ_W-1:0]          seq;
      logic signed [mbe_pkg::COORD_W-1:0] cre;
      logic signed [mbe_pkg::COORD_W-1:0] cim;
      logic signed [mbe_pkg::COORD_W-1:0] x;
      logic signed [mbe_pkg::COORD_W-1:0] y;
      logic [mbe_pkg::COUNT_W-1:0]        count;
   } slot_type;

   logic                               a_valid_ff, b_valid_ff, c_valid_ff, d_valid_ff;
   logic                               a_valid_in;
   slot_type                           a_ff, b_ff, c_ff, d_ff, a_in, wb;
   logic signed [mbe_pkg::PROD_W-1:0]  xx_ff, yy_ff, xy_ff, xx_in, yy_in, xy_in;
   logic signed [mbe_pkg::COORD_W-1:0] nx_c_ff, ny_c_ff, nx_d_ff, ny_d_ff, nx_in, ny_in;
   logic signed [mbe_pkg::PROD_W-1:0]  qx_ff, qy_ff, qx_in, qy_in;
   logic [mbe_pkg::MAG_W-1:0]          mag;
   logic [mbe_pkg::COUNT_W:0]          count_next;
   logic [mbe_pkg::SEQ_W-1:0]          in_seq_ff, in_seq_in, out_seq_ff, out_seq_in;
   logic                               retire, inject;

   // stage a: the three products of z
   assign xx_in = a_ff.x * a_ff.x;
   assign yy_in = a_ff.y * a_ff.y;
   assign xy_in = a_ff.x * a_ff.y;

   // stage b: new z, floor scaling of the cross term, saturated
   assign nx_in = mbe_pkg::sat_coord(mbe_pkg::WIDE_W'(xx_ff >>> mbe_pkg::FRAC_BITS)
                                   - mbe_pkg::WIDE_W'(yy_ff >>> mbe_pkg::FRAC_BITS)
                                   + mbe_pkg::WIDE_W'(b_ff.cre));
   assign ny_in = mbe_pkg::sat_coord(mbe_pkg::WIDE_W'(xy_ff >>> (mbe_pkg::FRAC_BITS - 1))
                                   + mbe_pkg::WIDE_W'(b_ff.cim));

   // stage c: squares of the new z
   assign qx_in = nx_c_ff * nx_c_ff;
   assign qy_in = ny_c_ff * ny_c_ff;

   // stage d: magnitude check and loop decision
   always_comb begin
      mag        = mbe_pkg::MAG_W'(qx_ff >>> mbe_pkg::FRAC_BITS)
                 + mbe_pkg::MAG_W'(qy_ff >>> mbe_pkg::FRAC_BITS);
      count_next = {1'b0, d_ff.count} + 1'b1;
      wb         = d_ff;
      if (!d_ff.done) begin
         wb.x     = nx_d_ff;
         wb.y     = ny_d_ff;
         wb.count = count_next[mbe_pkg::COUNT_W-1:0];
         wb.done  = !((count_next < {1'b0, max_iterations}) && (mag < mbe_pkg::MAG_LIMIT));
      end
   end

   // retire the oldest finished item, refill the freed slot
   assign retire  = d_valid_ff && wb.done && (wb.seq == out_seq_ff);
   assign inject  = pt_valid && (!d_valid_ff || retire);
   assign pt_take = inject;

   always_comb begin
      a_valid_in = 1'b0;
      a_in       = wb;
      if (d_valid_ff && !retire) begin
         a_valid_in = 1'b1;
      end else if (inject) begin
         a_valid_in = 1'b1;
         a_in.done  = (max_iterations == '0);
         a_in.seq   = in_seq_ff;
         a_in.cre   = pt_beat.cre;
         a_in.cim   = pt_beat.cim;
         a_in.x     = '0;
         a_in.y     = '0;
         a_in.count = '0;
      end
      in_seq_in  = inject ? in_seq_ff + 1'b1 : in_seq_ff;
      out_seq_in = retire ? out_seq_ff + 1'b1 : out_seq_ff;
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
         d_valid_ff <= 1'b0;
         in_seq_ff  <= '0;
         out_seq_ff <= '0;
      end else begin
         a_valid_ff <= a_valid_in;
         b_valid_ff <= a_valid_ff;
         c_valid_ff <= b_valid_ff;
         d_valid_ff <= c_valid_ff;
         in_seq_ff  <= in_seq_in;
         out_seq_ff <= out_seq_in;
      end
   end

   // ring payload, always moving
   always_ff @(posedge clock) begin
      a_ff    <= a_in;
      b_ff    <= a_ff;
      xx_ff   <= xx_in;
      yy_ff   <= yy_in;
      xy_ff   <= xy_in;
      c_ff    <= b_ff;
      nx_c_ff <= nx_in;
      ny_c_ff <= ny_in;
      d_ff    <= c_ff;
      nx_d_ff <= nx_c_ff;
      ny_d_ff <= ny_c_ff;
      qx_ff   <= qx_in;
      qy_ff   <= qy_in;
   end

   assign rsp_strobe          = retire;
   assign rsp_iteration_count = wb.count;

`ifndef ASSERT_OFF
   // a retired count never passes the limit
   count_in_range: assert property (@(posedge clock) disable iff (reset)
      retire |-> (wb.count <= max_iterations))
      else $error("retired count above limit");

   // retire order advances by one per beat
   retire_order: assert property (@(posedge clock) disable iff (reset)
      retire |=> (out_seq_ff == $past(out_seq_ff) + 1'b1))
      else $error("retire sequence skipped");

   // a new item only lands in a free slot
   inject_free: assert property (@(posedge clock) disable iff (reset)
      inject |-> (!d_valid_ff || retire))
      else $error("inject over a live slot");
`endif

endmodule

// ===== rtl/core/mandelbrot_escape_time.sv =====
// mandelbrot_escape_time: top level, config registers, mapper and iteration ring
// depends on mbe_pkg, mbe_coord, mbe_iter_ring
//
//  channel  | ports                                   | beat taken when
//  ---------+-----------------------------------------+---------------------------
//  request  | start, busy, req_column, req_row        | start && !busy
//  response | rsp_strobe, rsp_iteration_count         | rsp_strobe (no back pressure)
//  config   | csr_wen, csr_index, csr_wdata           | csr_wen
//
// an item goes through the mapper, then makes one pass round the ring per iteration
// (a multiply stage, an update stage, a square stage, a check stage); a zero
// count still makes one pass. up to 4 items share the ring, giving one iteration
// per cycle in total while all four are still iterating. results leave in
// request order; busy rises when the mapper's three stages are all full. reset
// clears all items and loads the register defaults.
module mandelbrot_escape_time (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [mbe_pkg::INDEX_W-1:0]         req_column,
   input  logic [mbe_pkg::INDEX_W-1:0]         req_row,
   output logic                                rsp_strobe,
   output logic [mbe_pkg::COUNT_W-1:0]         rsp_iteration_count,
   input  logic                                csr_wen,
   input  logic [mbe_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [mbe_pkg::COORD_W-1:0]         csr_wdata
);

   logic [mbe_pkg::COUNT_W-1:0]        max_iter_ff;
   logic signed [mbe_pkg::COORD_W-1:0] real_origin_ff, real_step_ff;
   logic signed [mbe_pkg::COORD_W-1:0] imag_origin_ff, imag_step_ff;
   logic                               full, accept, pt_valid, pt_take;
   mbe_pkg::point_type                 pt_beat;

   assign busy   = full;
   assign accept = start && !full;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         max_iter_ff    <= mbe_pkg::RST_MAX_ITER;
         real_origin_ff <= mbe_pkg::RST_ORIGIN;
         real_step_ff   <= mbe_pkg::RST_STEP;
         imag_origin_ff <= mbe_pkg::RST_ORIGIN;
         imag_step_ff   <= mbe_pkg::RST_STEP;
      end else if (csr_wen) begin
         case (csr_index)
            mbe_pkg::CSR_MAX_ITER:    max_iter_ff    <= csr_wdata[mbe_pkg::COUNT_W-1:0];
            mbe_pkg::CSR_REAL_ORIGIN: real_origin_ff <= csr_wdata;
            mbe_pkg::CSR_REAL_STEP:   real_step_ff   <= csr_wdata;
            mbe_pkg::CSR_IMAG_ORIGIN: imag_origin_ff <= csr_wdata;
            mbe_pkg::CSR_IMAG_STEP:   imag_step_ff   <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // pixel to point c
   mbe_coord u_coord (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .column      (req_column),
      .row         (req_row),
      .real_origin (real_origin_ff),
      .real_step   (real_step_ff),
      .imag_origin (imag_origin_ff),
      .imag_step   (imag_step_ff),
      .full        (full),
      .pt_valid    (pt_valid),
      .pt_beat     (pt_beat),
      .pt_take     (pt_take)
   );

   // iteration ring
   mbe_iter_ring u_ring (
      .clock               (clock),
      .reset               (reset),
      .max_iterations      (max_iter_ff),
      .pt_valid            (pt_valid),
      .pt_beat             (pt_beat),
      .pt_take             (pt_take),
      .rsp_strobe          (rsp_strobe),
      .rsp_iteration_count (rsp_iteration_count)
   );

endmodule
